FILE: sv/aes_encrypt_round_unit_defines.svh
// Assertion macros for the AES encryption round unit.
// Depends on clk and arst_n being visible where the macros are used.
`ifndef AES_ENCRYPT_ROUND_UNIT_DEFINES_SVH
`define AES_ENCRYPT_ROUND_UNIT_DEFINES_SVH

`ifndef SYNTH

`define AESR_ASSERT_IMPL(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) \
		else $error("aesr assertion failed");

`define AESR_ASSERT_NEXT(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) \
		else $error("aesr assertion failed");

`define AESR_ASSERT_LAT4(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> ##4 (b)) \
		else $error("aesr assertion failed");

`else

`define AESR_ASSERT_IMPL(lbl, a, b)
`define AESR_ASSERT_NEXT(lbl, a, b)
`define AESR_ASSERT_LAT4(lbl, a, b)

`endif

`endif

FILE: sv/aesr_pkg.sv
// Types, constants and round functions of the AES encryption round unit.
// No dependencies.
package aesr_pkg;

	localparam logic [1:0] KIND_INIT  = 2'd0;
	localparam logic [1:0] KIND_MID   = 2'd1;
	localparam logic [1:0] KIND_FINAL = 2'd2;

	localparam int QDepth = 2;
	localparam int QPtrW  = 1;
	localparam int QCntW  = 2;

	typedef struct packed {
		logic [63:0] state_hi;
		logic [63:0] state_lo;
		logic [63:0] key_hi;
		logic [63:0] key_lo;
		logic [1:0]  round_kind;
	} req_t;

	typedef struct packed {
		logic [63:0] result_hi;
		logic [63:0] result_lo;
	} rsp_t;

	typedef struct packed {
		logic [127:0] state;
		logic [127:0] key;
		logic         sub_en;
		logic         mix_en;
	} op_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,
		8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,
		8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,
		8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,
		8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,
		8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,
		8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,
		8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,
		8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,
		8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,
		8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,
		8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,
		8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,
		8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,
		8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,
		8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,
		8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	function automatic logic [7:0] sbox(input logic [7:0] b);
		return SBOX[b];
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] b);
		return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
	endfunction

	// out[r][c] = S(in[r][(c+r) mod 4])
	function automatic logic [127:0] sub_shift(input logic [127:0] s);
		logic [127:0] o;
		int src;
		o = '0;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				src = 4 * ((c + r) & 3) + r;
				o[127 - 8 * (4 * c + r) -: 8] = sbox(s[127 - 8 * src -: 8]);
			end
		end
		return o;
	endfunction

	function automatic logic [31:0] mix_col(input logic [31:0] a);
		logic [7:0] a0, a1, a2, a3, d0, d1, d2, d3;
		a0 = a[31:24];
		a1 = a[23:16];
		a2 = a[15:8];
		a3 = a[7:0];
		d0 = xtime(a0);
		d1 = xtime(a1);
		d2 = xtime(a2);
		d3 = xtime(a3);
		return {d0 ^ d1 ^ a1 ^ a2 ^ a3,
			a0 ^ d1 ^ d2 ^ a2 ^ a3,
			a0 ^ a1 ^ d2 ^ d3 ^ a3,
			d0 ^ a0 ^ a1 ^ a2 ^ d3};
	endfunction

	function automatic logic [127:0] mix_cols(input logic [127:0] s);
		logic [127:0] o;
		o = '0;
		for (int c = 0; c < 4; c++) begin
			o[127 - 32 * c -: 32] = mix_col(s[127 - 32 * c -: 32]);
		end
		return o;
	endfunction

endpackage

FILE: sv/aesr_front.sv
// Front stage of the AES round unit: accepts an item and decodes the round kind.
// Depends on aesr_pkg.
module aesr_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  aesr_pkg::req_t req,
	output logic          busy,
	input  logic          q_ready,
	output logic          push,
	output aesr_pkg::op_t  op
);

	logic          vld_s1;
	aesr_pkg::op_t op_s1;
	aesr_pkg::op_t op_dec;
	logic          advance;
	logic          accept;

	assign advance = !vld_s1 || q_ready;
	assign busy    = !advance;
	assign accept  = start && advance;
	assign push    = vld_s1 && q_ready;
	assign op      = op_s1;

	always_comb begin
		op_dec.state = {req.state_hi, req.state_lo};
		op_dec.key   = {req.key_hi, req.key_lo};
		case (req.round_kind)
			aesr_pkg::KIND_MID: begin
				op_dec.sub_en = 1'b1;
				op_dec.mix_en = 1'b1;
			end
			aesr_pkg::KIND_FINAL: begin
				op_dec.sub_en = 1'b1;
				op_dec.mix_en = 1'b0;
			end
			aesr_pkg::KIND_INIT: begin
				op_dec.sub_en = 1'b0;
				op_dec.mix_en = 1'b0;
			end
			default: begin
				op_dec.sub_en = 1'b0;
				op_dec.mix_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (advance) begin
			vld_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1 <= op_dec;
		end
	end

endmodule

FILE: sv/aesr_queue.sv
// Short FIFO between the front and back parts of the AES round unit.
// Depends on aesr_pkg.
module aesr_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  aesr_pkg::op_t     push_op,
	input  logic             pop,
	output aesr_pkg::op_t     pop_op,
	output aesr_pkg::q_stat_t stat
);

	aesr_pkg::op_t             mem_q [aesr_pkg::QDepth];
	logic [aesr_pkg::QPtrW-1:0] wr_ptr_q;
	logic [aesr_pkg::QPtrW-1:0] rd_ptr_q;
	logic [aesr_pkg::QCntW-1:0] cnt_q;
	logic                      do_push;
	logic                      do_pop;

	assign stat.full  = (cnt_q == aesr_pkg::QCntW'(aesr_pkg::QDepth));
	assign stat.empty = (cnt_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign pop_op     = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_op;
		end
	end

endmodule

FILE: sv/aesr_back.sv
// Back part of the AES round unit: SubBytes/ShiftRows, then MixColumns and key add.
// Depends on aesr_pkg.
module aesr_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_vld,
	input  aesr_pkg::op_t  op,
	output logic          done,
	output aesr_pkg::rsp_t rsp
);

	logic           vld_s1;
	logic [127:0]   state_s1;
	logic [127:0]   key_s1;
	logic           mix_s1;
	logic           vld_s2;
	aesr_pkg::rsp_t rsp_s2;
	logic [127:0]   mixed;
	logic [127:0]   next_state;

	assign mixed      = mix_s1 ? aesr_pkg::mix_cols(state_s1) : state_s1;
	assign next_state = mixed ^ key_s1;
	assign done       = vld_s2;
	assign rsp        = rsp_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_vld) begin
			state_s1 <= op.sub_en ? aesr_pkg::sub_shift(op.state) : op.state;
			key_s1   <= op.key;
			mix_s1   <= op.mix_en;
		end
		if (vld_s1) begin
			rsp_s2.result_hi <= next_state[127:64];
			rsp_s2.result_lo <= next_state[63:0];
		end
	end

endmodule

FILE: sv/aes_encrypt_round_unit.sv
// AES-128 encryption round unit, top level.
// Depends on aesr_pkg, aesr_front, aesr_queue, aesr_back and the defines header.
//
// Usage:
//   Request channel: drive req (state, round key, round kind) and raise start;
//   an item is taken at a rising edge where start is high and busy is low.
//   Kind 0 (and the unused code 3) adds the round key only, kind 1 runs a full
//   middle round, kind 2 the final round without MixColumns.
//   Result channel: done is high for exactly one cycle with the new state on
//   rsp; the receiver has no way to hold it off.
//   Path: an accepted item passes the front register, the queue, the
//   SubBytes/ShiftRows register and the MixColumns/key register, in that order.
//   Throughput: one item per cycle; the back part pops the queue every cycle,
//   so busy stays low in normal use and rises only if the queue fills.
//   Reset: arst_n clears all valid flags and the queue pointers; items in
//   flight are dropped and no result is produced for them.
`include "aes_encrypt_round_unit_defines.svh"

module aes_encrypt_round_unit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  aesr_pkg::req_t req,
	output logic          busy,
	output logic          done,
	output aesr_pkg::rsp_t rsp
);

	logic              q_push;
	aesr_pkg::op_t     f_op;
	aesr_pkg::op_t     q_op;
	aesr_pkg::q_stat_t q_stat;
	logic              q_pop;

	assign q_pop = !q_stat.empty;

	aesr_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.req     (req),
		.busy    (busy),
		.q_ready (!q_stat.full),
		.push    (q_push),
		.op      (f_op)
	);

	aesr_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.push_op (f_op),
		.pop     (q_pop),
		.pop_op  (q_op),
		.stat    (q_stat)
	);

	aesr_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.in_vld (q_pop),
		.op     (q_op),
		.done   (done),
		.rsp    (rsp)
	);

	`AESR_ASSERT_IMPL(a_q_stat_sane, 1'b1, !(q_stat.full && q_stat.empty))
	`AESR_ASSERT_IMPL(a_busy_only_full, busy, q_stat.full)
	`AESR_ASSERT_NEXT(a_accept_reaches_q, start && !busy, q_push)
	`AESR_ASSERT_LAT4(a_fixed_latency, start && !busy, done)

endmodule

FILE: bench/tb.sv
// Testbench for aes_encrypt_round_unit: drives rounds of every kind and checks each new
// state against an in-bench round predictor. Its S-box is derived from GF(2^8) inverses.
// Depends on aesr_pkg and the RTL of aes_encrypt_round_unit.
module tb;

	localparam logic [1:0] KIND_SPARE = 2'd3;
	localparam int TIMEOUT = 2000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	aesr_pkg::req_t req = '0;
	logic busy;
	logic done;
	aesr_pkg::rsp_t rsp;

	logic [7:0] sbox_tbl [256];
	aesr_pkg::rsp_t pending_states [$];
	int n_fail = 0;

	aes_encrypt_round_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.req(req),
		.busy(busy),
		.done(done),
		.rsp(rsp)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [7:0] times2(input logic [7:0] b);
		logic [7:0] sh;
		sh = b << 1;
		return sh ^ ({8{b[7]}} & 8'h1b);
	endfunction

	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] p;
		logic [7:0] x;
		p = 8'h00;
		x = a;
		for (int i = 0; i < 8; i++) begin
			if (b[i])
				p = p ^ x;
			x = times2(x);
		end
		return p;
	endfunction

	function automatic void build_sbox();
		logic [7:0] bv;
		logic [7:0] bw;
		logic [7:0] inv;
		for (int v = 0; v < 256; v++) begin
			bv = v[7:0];
			inv = 8'h00;
			for (int w = 1; w < 256; w++) begin
				bw = w[7:0];
				if (gf_mul(bv, bw) == 8'h01)
					inv = bw;
			end
			sbox_tbl[v] = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
				^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
		end
	endfunction

	function automatic aesr_pkg::rsp_t encrypt_round(input aesr_pkg::req_t item);
		logic [127:0] blk;
		logic [127:0] key;
		logic [127:0] outv;
		logic [7:0] st [16];
		logic [7:0] sh [16];
		logic [7:0] a0, a1, a2, a3;
		aesr_pkg::rsp_t res;
		blk = {item.state_hi, item.state_lo};
		key = {item.key_hi, item.key_lo};
		for (int i = 0; i < 16; i++)
			st[i] = blk[127 - 8 * i -: 8];
		if (item.round_kind == aesr_pkg::KIND_MID
				|| item.round_kind == aesr_pkg::KIND_FINAL) begin
			for (int col = 0; col < 4; col++)
				for (int row = 0; row < 4; row++)
					sh[4 * col + row] = sbox_tbl[st[4 * ((col + row) % 4) + row]];
			st = sh;
		end
		if (item.round_kind == aesr_pkg::KIND_MID) begin
			for (int col = 0; col < 4; col++) begin
				a0 = st[4 * col];
				a1 = st[4 * col + 1];
				a2 = st[4 * col + 2];
				a3 = st[4 * col + 3];
				st[4 * col]     = times2(a0) ^ times2(a1) ^ a1 ^ a2 ^ a3;
				st[4 * col + 1] = a0 ^ times2(a1) ^ times2(a2) ^ a2 ^ a3;
				st[4 * col + 2] = a0 ^ a1 ^ times2(a2) ^ times2(a3) ^ a3;
				st[4 * col + 3] = times2(a0) ^ a0 ^ a1 ^ a2 ^ times2(a3);
			end
		end
		for (int i = 0; i < 16; i++)
			outv[127 - 8 * i -: 8] = st[i] ^ key[127 - 8 * i -: 8];
		res.result_hi = outv[127:64];
		res.result_lo = outv[63:0];
		return res;
	endfunction

	function automatic aesr_pkg::req_t make_round(input logic [63:0] sh,
			input logic [63:0] sl, input logic [63:0] kh, input logic [63:0] kl,
			input logic [1:0] kind);
		aesr_pkg::req_t item;
		item.state_hi = sh;
		item.state_lo = sl;
		item.key_hi = kh;
		item.key_lo = kl;
		item.round_kind = kind;
		return item;
	endfunction

	function automatic aesr_pkg::req_t random_round(input logic [1:0] kind);
		return make_round({$urandom, $urandom}, {$urandom, $urandom},
			{$urandom, $urandom}, {$urandom, $urandom}, kind);
	endfunction

	function automatic logic [1:0] pick_kind();
		int r;
		r = $urandom_range(0, 9);
		if (r < 2)
			return aesr_pkg::KIND_INIT;
		else if (r < 6)
			return aesr_pkg::KIND_MID;
		else if (r < 9)
			return aesr_pkg::KIND_FINAL;
		else
			return KIND_SPARE;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	task automatic send_round(input aesr_pkg::req_t item, input int gap);
		repeat (gap) begin
			@(negedge clk);
			start <= 1'b0;
			req <= random_round(pick_kind());
		end
		@(negedge clk);
		start <= 1'b1;
		req <= item;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		pending_states.push_back(encrypt_round(item));
	endtask

	task automatic idle_until_drained();
		@(negedge clk);
		start <= 1'b0;
		while (pending_states.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_directed();
		logic [1:0] kinds [4];
		kinds = '{aesr_pkg::KIND_INIT, aesr_pkg::KIND_MID, aesr_pkg::KIND_FINAL, KIND_SPARE};
		for (int k = 0; k < 4; k++) begin
			send_round(make_round('0, '0, '0, '0, kinds[k]), pick_gap());
			send_round(make_round('1, '1, '1, '1, kinds[k]), pick_gap());
		end
		send_round(make_round(64'h3243f6a8885a308d, 64'h313198a2e0370734,
			64'h2b7e151628aed2a6, 64'habf7158809cf4f3c, aesr_pkg::KIND_INIT), 0);
		send_round(make_round(64'h193de3bea0f4e22b, 64'h9ac68d2ae9f84808,
			64'ha0fafe1788542cb1, 64'h23a339392a6c7605, aesr_pkg::KIND_MID), 0);
		send_round(make_round(64'heb598b1b402ea1c3, 64'hf23813421e84e7d2,
			64'hd014f9a8c9ee2589, 64'he13f0cc8b6630ca6, aesr_pkg::KIND_FINAL), 0);
		send_round(make_round({8{8'h55}}, {8{8'haa}}, {8{8'haa}}, {8{8'h55}},
			aesr_pkg::KIND_MID), 1);
		send_round(make_round('0, '0, '1, '1, aesr_pkg::KIND_FINAL), 0);
	endtask

	task automatic test_sbox_sweep();
		logic [127:0] blk;
		aesr_pkg::req_t item;
		for (int k = 0; k < 2; k++) begin
			for (int g = 0; g < 16; g++) begin
				for (int i = 0; i < 16; i++)
					blk[127 - 8 * i -: 8] = 8'(16 * g + i);
				item = random_round(k == 0 ? aesr_pkg::KIND_MID : aesr_pkg::KIND_FINAL);
				item.state_hi = blk[127:64];
				item.state_lo = blk[63:0];
				send_round(item, pick_gap());
			end
		end
	endtask

	task automatic test_back_to_back();
		for (int n = 0; n < 400; n++)
			send_round(random_round(pick_kind()), 0);
	endtask

	task automatic test_random_gaps();
		for (int n = 0; n < 1200; n++)
			send_round(random_round(pick_kind()), pick_gap());
	endtask

	task automatic test_pause_drain();
		for (int b = 0; b < 10; b++) begin
			for (int n = 0; n < 30; n++)
				send_round(random_round(pick_kind()), pick_gap());
			idle_until_drained();
		end
	endtask

	always @(posedge clk) begin
		aesr_pkg::rsp_t want;
		if (arst_n) begin
			if ($isunknown(done)) begin
				$error("done: expected 0 or 1, got %b", done);
				n_fail++;
			end else if (done) begin
				if (pending_states.size() == 0) begin
					$error("result: expected none, got %h %h", rsp.result_hi, rsp.result_lo);
					n_fail++;
				end else begin
					want = pending_states.pop_front();
					if (rsp.result_hi !== want.result_hi) begin
						$error("result_hi: expected %h, got %h", want.result_hi, rsp.result_hi);
						n_fail++;
					end
					if (rsp.result_lo !== want.result_lo) begin
						$error("result_lo: expected %h, got %h", want.result_lo, rsp.result_lo);
						n_fail++;
					end
				end
			end
		end
	end

	initial begin
		build_sbox();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_sbox_sweep();
		test_back_to_back();
		test_random_gaps();
		test_pause_drain();
		idle_until_drained();
		repeat (12) @(posedge clk);
		if (n_fail == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#TIMEOUT;
		$display("tb: failure");
		$finish;
	end

endmodule

FILE: files.f
+incdir+sv
sv/aesr_pkg.sv
sv/aesr_front.sv
sv/aesr_queue.sv
sv/aesr_back.sv
sv/aes_encrypt_round_unit.sv
bench/tb.sv
